// ----- src/tccs_pkg.sv -----
package tccs_pkg;

	localparam int CELL_HEIGHT_DEF = 16;
	localparam int CELL_WIDTH_DEF  = 8;
	localparam int OFFSET_BITS_DEF = 26;

	// width of offset fields on the result stream
	localparam int OFS_W = 26;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_BS  = 8'd8;
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	localparam logic [8:0] TAB_STOP = 9'd4;
	localparam logic [7:0] TAB_MASK = 8'hFC;

	localparam logic [2:0] REG_COLUMNS = 3'd0;
	localparam logic [2:0] REG_ROWS    = 3'd1;
	localparam logic [2:0] REG_PITCH   = 3'd2;
	localparam logic [2:0] REG_WIDE    = 3'd3;
	localparam logic [2:0] REG_BUFFER  = 3'd4;

	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_SCROLL = 1'b1;

	typedef struct packed {
		logic [7:0]  text_columns;
		logic [6:0]  text_rows;
		logic [15:0] line_pitch;
		logic        wide_pixels;
		logic [25:0] buffer_bytes;
	} cfg_t;

	// one classified character: a draw, a scroll, or both
	typedef struct packed {
		logic       draw;
		logic       scroll;
		logic [7:0] glyph;
		logic [7:0] col;
		logic [6:0] row;
		logic [6:0] last_row;
	} cmd_t;

endpackage

// ----- src/tccs_front.sv -----
module tccs_front
	import tccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_code
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_entry
);

	logic [7:0] col_q;
	logic [6:0] row_q;
	logic [8:0] col_mv;
	logic [7:0] row_mv;
	logic [8:0] col_nx;
	logic [7:0] row_nx;
	logic       draw;
	logic       scroll;
	logic [6:0] last_row;
	logic       accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign last_row = cfg.text_rows - 7'd1;

	always_comb begin
		col_mv = {1'b0, col_q};
		row_mv = {1'b0, row_q};
		draw   = 1'b0;
		unique case (s_tdata)
			CHAR_LF: begin
				col_mv = '0;
				row_mv = {1'b0, row_q} + 8'd1;
			end
			CHAR_CR: begin
				col_mv = '0;
			end
			CHAR_TAB: begin
				col_mv = {1'b0, col_q & TAB_MASK} + TAB_STOP;
			end
			CHAR_BS: begin
				if (col_q != 8'd0) begin
					col_mv = {1'b0, col_q - 8'd1};
				end else if (row_q != 7'd0) begin
					col_mv = {1'b0, cfg.text_columns - 8'd1};
					row_mv = {1'b0, row_q - 7'd1};
				end
			end
			default: begin
				draw   = 1'b1;
				col_mv = {1'b0, col_q} + 9'd1;
			end
		endcase

		col_nx = col_mv;
		row_nx = row_mv;
		if (col_mv >= {1'b0, cfg.text_columns}) begin
			col_nx = '0;
			row_nx = row_mv + 8'd1;
		end

		scroll = (row_nx >= {1'b0, cfg.text_rows});
		if (scroll) begin
			row_nx = {1'b0, last_row};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nx[7:0];
			row_q <= row_nx[6:0];
		end
	end

	assign q_push           = accept && (draw || scroll);
	assign q_entry.draw     = draw;
	assign q_entry.scroll   = scroll;
	assign q_entry.glyph    = s_tdata;
	assign q_entry.col      = col_q;
	assign q_entry.row      = row_q;
	assign q_entry.last_row = last_row;

endmodule

// ----- src/tccs_queue.sv -----
module tccs_queue
	import tccs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t entry,
	output logic full,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) !head_valid |-> !pop)
		else $error("queue popped while empty");

endmodule

// ----- src/tccs_back.sv -----
module tccs_back
	import tccs_pkg::*;
#(
	parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
	parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  cmd_t        head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // glyph_code, cell_col, cell_row, byte_offset, ring_base, pad
	output logic        m_tuser,  // action
	output logic        m_tlast   // last_of_run
);

	localparam int RCH_W  = 7 + $clog2(CELL_HEIGHT) + 1;
	localparam int PROD_W = RCH_W + 16;
	localparam int COLP_W = 8 + $clog2(CELL_WIDTH) + 3;
	localparam int MAX_A  = (OFFSET_BITS > PROD_W) ? OFFSET_BITS : PROD_W;
	localparam int SUM_W  = ((MAX_A > OFS_W) ? MAX_A : OFS_W) + 2;
	localparam int STEP_W = ((OFFSET_BITS > OFS_W) ? OFFSET_BITS : OFS_W) + 1;
	localparam int CNT_W  = $clog2(CELL_HEIGHT);

	typedef enum logic [2:0] {
		BK_CMD    = 3'b001,
		BK_STEP   = 3'b010,
		BK_SCROLL = 3'b100
	} bk_state_t;

	bk_state_t        state_q, state_d;
	logic [CNT_W-1:0] step_cnt_q;
	logic [OFFSET_BITS-1:0] base_q;

	logic                   en;
	logic                   iss_valid;
	logic                   iss_action;
	logic [7:0]             iss_glyph;
	logic [7:0]             iss_col;
	logic [6:0]             iss_row;
	logic                   iss_last;

	logic [STEP_W-1:0]      step_sum;
	logic [STEP_W-1:0]      step_wrap;

	logic [RCH_W-1:0]       row_ch;
	logic [COLP_W-1:0]      col_cw;

	logic                   v_s1, action_s1, last_s1;
	logic [7:0]             glyph_s1, col_s1;
	logic [6:0]             row_s1;
	logic [OFFSET_BITS-1:0] base_s1;
	logic [PROD_W-1:0]      prod_s1;
	logic [COLP_W-1:0]      colp_s1;

	logic                   v_s2, action_s2, last_s2;
	logic [7:0]             glyph_s2, col_s2;
	logic [6:0]             row_s2;
	logic [OFFSET_BITS-1:0] base_s2;
	logic [SUM_W-1:0]       sum_s2;

	logic [SUM_W-1:0]       sum_wrap;
	logic [OFFSET_BITS-1:0] off_masked;

	logic                   out_valid_q, out_action_q, out_last_q;
	logic [7:0]             out_glyph_q, out_col_q;
	logic [6:0]             out_row_q;
	logic [OFS_W-1:0]       out_off_q, out_base_q;

	// the whole pipeline moves when the output register can take a value
	assign en = !out_valid_q || m_tready;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		iss_valid  = 1'b0;
		iss_action = ACT_DRAW;
		iss_glyph  = head.glyph;
		iss_col    = head.col;
		iss_row    = head.row;
		iss_last   = !head.scroll;
		unique case (state_q)
			BK_CMD: begin
				if (head_valid) begin
					if (head.draw) begin
						if (en) begin
							iss_valid = 1'b1;
							if (head.scroll) begin
								state_d = BK_STEP;
							end else begin
								pop = 1'b1;
							end
						end
					end else begin
						state_d = BK_STEP;
					end
				end
			end
			BK_STEP: begin
				if (step_cnt_q == CNT_W'(CELL_HEIGHT - 1)) begin
					state_d = BK_SCROLL;
				end
			end
			BK_SCROLL: begin
				iss_action = ACT_SCROLL;
				iss_glyph  = '0;
				iss_col    = '0;
				iss_row    = head.last_row;
				iss_last   = 1'b1;
				if (en) begin
					iss_valid = 1'b1;
					pop       = 1'b1;
					state_d   = BK_CMD;
				end
			end
			default: begin
				state_d = BK_CMD;
			end
		endcase
	end

	// one scan line of base advance per cycle
	assign step_sum  = STEP_W'(base_q) + STEP_W'(cfg.line_pitch);
	assign step_wrap = (step_sum >= STEP_W'(cfg.buffer_bytes)) ?
		step_sum - STEP_W'(cfg.buffer_bytes) : step_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CMD;
			step_cnt_q <= '0;
			base_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_STEP) begin
				step_cnt_q <= step_cnt_q + 1'b1;
				base_q     <= OFFSET_BITS'(step_wrap);
			end else begin
				step_cnt_q <= '0;
			end
		end
	end

	assign row_ch = RCH_W'(iss_row) * RCH_W'(CELL_HEIGHT);
	assign col_cw = COLP_W'(iss_col) * COLP_W'(CELL_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= iss_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= iss_action;
			last_s1   <= iss_last;
			glyph_s1  <= iss_glyph;
			col_s1    <= iss_col;
			row_s1    <= iss_row;
			base_s1   <= base_q;
			prod_s1   <= PROD_W'(row_ch) * PROD_W'(cfg.line_pitch);
			colp_s1   <= cfg.wide_pixels ? (col_cw << 2) : (col_cw << 1);

			action_s2 <= action_s1;
			last_s2   <= last_s1;
			glyph_s2  <= glyph_s1;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			base_s2   <= base_s1;
			sum_s2    <= SUM_W'(base_s1) + SUM_W'(prod_s1) + SUM_W'(colp_s1);

			out_action_q <= action_s2;
			out_last_q   <= last_s2;
			out_glyph_q  <= glyph_s2;
			out_col_q    <= col_s2;
			out_row_q    <= row_s2;
			out_off_q    <= OFS_W'(off_masked);
			out_base_q   <= OFS_W'(base_s2);
		end
	end

	// wrap the cell offset once around the ring
	assign sum_wrap = (sum_s2 >= SUM_W'(cfg.buffer_bytes)) ?
		sum_s2 - SUM_W'(cfg.buffer_bytes) : sum_s2;
	assign off_masked = OFFSET_BITS'(sum_wrap);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_action_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_base_q, out_off_q, out_row_q, out_col_q, out_glyph_q};

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> iss_valid)
		else $error("command retired without a result");
	assert property (@(posedge clk) disable iff (!arst_n) iss_valid |-> en)
		else $error("result issued into a stalled pipeline");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_action_q == ACT_SCROLL) |-> out_last_q)
		else $error("scroll result not marked last");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_STEP) |=> (state_q == BK_STEP || state_q == BK_SCROLL))
		else $error("base advance left before scroll issue");

endmodule

// ----- src/text_console_cursor_scroll.sv -----
// an accepted character enters the command queue, is issued by the back end and passes
// stages s1 and s2 into the output register; a scroll follows its draw once the ring base
// has advanced by CELL_HEIGHT scan lines; throughput: one draw per cycle while the output
// accepts, while a scroll holds the back end for the iterative base advance of one scan line per cycle
// reset: cursor, ring base, command queue and pipeline cleared, registers at defaults
module text_console_cursor_scroll
	import tccs_pkg::*;
#(
	parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
	parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [25:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // glyph_code, cell_col, cell_row, byte_offset, ring_base, pad
	output logic        m_tuser,   // action
	output logic        m_tlast    // last_of_run
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t q_entry;
	logic head_valid;
	cmd_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_columns <= 8'd80;
			cfg_q.text_rows    <= 7'd48;
			cfg_q.line_pitch   <= 16'd4096;
			cfg_q.wide_pixels  <= 1'b1;
			cfg_q.buffer_bytes <= 26'd3145728;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS: cfg_q.text_columns <= cfg_data[7:0];
				REG_ROWS:    cfg_q.text_rows    <= cfg_data[6:0];
				REG_PITCH:   cfg_q.line_pitch   <= cfg_data[15:0];
				REG_WIDE:    cfg_q.wide_pixels  <= cfg_data[0];
				REG_BUFFER:  cfg_q.buffer_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	tccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	tccs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.entry      (q_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	tccs_back #(
		.CELL_HEIGHT (CELL_HEIGHT),
		.CELL_WIDTH  (CELL_WIDTH),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import tccs_pkg::*;

	localparam int NUM_PHASES    = 9;
	localparam int CHARS_PER_SET = 165;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic        action;
		logic [7:0]  glyph;
		logic [7:0]  col;
		logic [6:0]  row;
		logic [25:0] ofs;
		logic [25:0] base;
		logic        last;
	} console_cmd_t;

	// tracks cursor and ring base, holds the draw/scroll commands still owed by the block
	class console_tracker;
		logic [7:0]   columns;
		logic [6:0]   rows;
		logic [15:0]  pitch;
		logic         wide;
		logic [25:0]  ring_size;
		logic [7:0]   cur_col;
		logic [6:0]   cur_row;
		logic [25:0]  base;
		console_cmd_t due_cmds[$];
		int unsigned  fails;

		function new();
			columns   = 8'd80;
			rows      = 7'd48;
			pitch     = 16'd4096;
			wide      = 1'b1;
			ring_size = 26'd3145728;
			cur_col   = '0;
			cur_row   = '0;
			base      = '0;
			fails     = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [25:0] val);
			case (idx)
				REG_COLUMNS: columns = val[7:0];
				REG_ROWS: rows = val[6:0];
				REG_PITCH: pitch = val[15:0];
				REG_WIDE: wide = val[0];
				REG_BUFFER: ring_size = val[25:0];
				default: ;
			endcase
		endfunction

		function longint unsigned wrap_ring(longint unsigned v);
			if (v >= longint'(ring_size))
				v = v - ring_size;
			return v & ((64'd1 << OFFSET_BITS_DEF) - 1);
		endfunction

		function void take_char(logic [7:0] c);
			int unsigned       col;
			int unsigned       row;
			longint unsigned   bpp;
			longint unsigned   cell_ofs;
			longint unsigned   last_row;
			longint unsigned   b;
			console_cmd_t      cmd;
			console_cmd_t      run[$];
			col = cur_col;
			row = cur_row;
			case (c)
				CHAR_LF: begin
					col = 0;
					row++;
				end
				CHAR_CR: col = 0;
				CHAR_TAB: col = (col & ~32'd3) + 4;
				CHAR_BS: begin
					if (col > 0)
						col--;
					else if (row > 0) begin
						col = (int'(columns) - 1) & 'hFF;
						row--;
					end
				end
				default: begin
					bpp = wide ? 4 : 2;
					cell_ofs = longint'(row) * CELL_HEIGHT_DEF * pitch
					         + longint'(col) * CELL_WIDTH_DEF * bpp;
					cmd.action = ACT_DRAW;
					cmd.glyph  = c;
					cmd.col    = col[7:0];
					cmd.row    = row[6:0];
					cmd.ofs    = wrap_ring(longint'(base) + cell_ofs);
					cmd.base   = base;
					cmd.last   = 1'b0;
					run.push_back(cmd);
					col++;
				end
			endcase
			if (col >= columns) begin
				col = 0;
				row++;
			end
			if (row >= rows) begin
				last_row = (longint'(rows) - 1) & 'h7F;
				// ring base steps one scan line at a time, each wrapped once
				for (int i = 0; i < CELL_HEIGHT_DEF; i++) begin
					b = longint'(base) + pitch;
					if (b >= longint'(ring_size))
						b = b - ring_size;
					base = b[25:0];
				end
				cmd.action = ACT_SCROLL;
				cmd.glyph  = '0;
				cmd.col    = '0;
				cmd.row    = last_row[6:0];
				cmd.ofs    = wrap_ring(longint'(base)
				                       + longint'(pitch) * last_row * CELL_HEIGHT_DEF);
				cmd.base   = base;
				cmd.last   = 1'b0;
				run.push_back(cmd);
				row = last_row;
			end
			cur_col = col[7:0];
			cur_row = row[6:0];
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				due_cmds.push_back(run[i]);
		endfunction

		function void match_cmd(logic act, logic [79:0] data, logic lst);
			console_cmd_t want;
			if (due_cmds.size() == 0) begin
				$error("unexpected transaction: action %0d tdata %h", act, data);
				fails++;
				return;
			end
			want = due_cmds.pop_front();
			if (act !== want.action) begin
				$error("action: expected %0d, got %0d", want.action, act);
				fails++;
			end
			if (data[7:0] !== want.glyph) begin
				$error("glyph_code: expected %0d, got %0d", want.glyph, data[7:0]);
				fails++;
			end
			if (data[15:8] !== want.col) begin
				$error("cell_col: expected %0d, got %0d", want.col, data[15:8]);
				fails++;
			end
			if (data[22:16] !== want.row) begin
				$error("cell_row: expected %0d, got %0d", want.row, data[22:16]);
				fails++;
			end
			if (data[48:23] !== want.ofs) begin
				$error("byte_offset: expected %0d, got %0d", want.ofs, data[48:23]);
				fails++;
			end
			if (data[74:49] !== want.base) begin
				$error("ring_base: expected %0d, got %0d", want.base, data[74:49]);
				fails++;
			end
			if (lst !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, lst);
				fails++;
			end
		endfunction

		function int pending();
			return due_cmds.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [25:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // char_code
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // glyph_code, cell_col, cell_row, byte_offset, ring_base, pad
	logic        m_tuser;   // action
	logic        m_tlast;   // last_of_run

	console_tracker tracker;
	int             idle_pct;

	text_console_cursor_scroll i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_cmd(m_tuser, m_tdata, m_tlast);
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		tracker.take_char(c);
		@(negedge clk);
	endtask

	// control characters draw no glyph on the output, so give the pipeline time to empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input logic [7:0] cols, input logic [6:0] nrows,
	                            input logic [15:0] pitch, input logic wide,
	                            input logic [25:0] ring_size);
		logic [2:0]  idx [5];
		logic [25:0] val [5];
		idx = '{REG_COLUMNS, REG_ROWS, REG_PITCH, REG_WIDE, REG_BUFFER};
		val = '{26'(cols), 26'(nrows), 26'(pitch), 26'(wide), ring_size};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			tracker.set_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly glyphs, with a steady share of cursor controls
	function automatic logic [7:0] pick_char();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return CHAR_LF;
		else if (roll < 14)
			return CHAR_CR;
		else if (roll < 20)
			return CHAR_TAB;
		else if (roll < 27)
			return CHAR_BS;
		return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [7:0] opening [18];
		opening = '{CHAR_BS, 8'h41, 8'h00, 8'hFF, 8'h7F, 8'h80, CHAR_TAB, CHAR_TAB,
		            CHAR_BS, CHAR_CR, CHAR_BS, CHAR_LF, CHAR_BS, 8'h78, 8'h79,
		            CHAR_LF, 8'h55, 8'hAA};
		tracker   = new();
		idle_pct  = 19;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			send_char(opening[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			idle_pct = 19;
			case (ph)
				0: ;
				1: program_regs(8'd255, 7'd127, 16'hFFFF, 1'b1, 26'h3FFFFFF);
				// cursor is left far out by the large screen, now it shrinks
				2: program_regs(8'd10, 7'd5, 16'd100, 1'b0, 26'd5000);
				3: begin
					program_regs(8'd1, 7'd1, 16'd1, 1'b0, 26'd1);
					idle_pct = 0;
				end
				4: program_regs(8'd0, 7'd0, 16'd0, 1'b0, 26'd0);
				5: program_regs(8'd0, 7'd20, 16'd4096, 1'b1, 26'd65536);
				default: program_regs(8'($urandom_range(255, 1)), 7'($urandom_range(127, 1)),
				                      16'($urandom_range(65535, 1)), 1'($urandom_range(1)),
				                      26'($urandom_range(26'h3FFFFFF, 1)));
			endcase
			repeat (CHARS_PER_SET) send_char(pick_char());
		end

		wait_idle();
		if (tracker.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
